// ===== rtl/core/mesh_edge_adjacency_table_assert.svh =====
// Assertion macros for the checker file of the edge adjacency table.
// Uses the checker's clk and rst signals; no other dependencies.
`ifndef MESH_EDGE_ADJACENCY_TABLE_ASSERT_SVH
`define MESH_EDGE_ADJACENCY_TABLE_ASSERT_SVH

// same-cycle implication
`define MEA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edge table check failed");

// next-cycle implication
`define MEA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edge table check failed");

`endif

// ===== rtl/core/mea_pkg.sv =====
// Package for the mesh edge adjacency table: sizes, hash constants, codes,
// the slot word layout, sequencer states and the store request bundle.
// No dependencies.
package mea_pkg;

  localparam int HASH_SLOTS    = 8192;
  localparam int SLOT_BITS     = 13;
  localparam int COUNT_BITS    = 14;
  localparam int MAX_TRIANGLES = 2048;
  localparam int TRI_BITS      = 12;
  localparam int TRI_ID_BITS   = 11;
  localparam int VERTEX_BITS   = 20;

  localparam logic [31:0] HASH_MUL_LOW  = 32'd73856093;
  localparam logic [31:0] HASH_MUL_HIGH = 32'd19349663;
  // only the low slot bits of each product reach the slot index
  localparam logic [SLOT_BITS-1:0] HASH_LOW_TRIM  = HASH_MUL_LOW[SLOT_BITS-1:0];
  localparam logic [SLOT_BITS-1:0] HASH_HIGH_TRIM = HASH_MUL_HIGH[SLOT_BITS-1:0];

  localparam logic [TRI_BITS-1:0] NO_TRI    = '1;
  localparam logic [TRI_BITS-1:0] TRI_LIMIT = TRI_BITS'(MAX_TRIANGLES);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_TRI_LIMIT = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic                   valid;
    logic [VERTEX_BITS-1:0] lo;
    logic [VERTEX_BITS-1:0] hi;
    logic [TRI_ID_BITS-1:0] first;
    logic [TRI_BITS-1:0]    second;
  } slot_t;

  typedef struct packed {
    logic                 slot_we;
    logic                 slot_re;
    logic [SLOT_BITS-1:0] slot_addr;
    slot_t                slot_wdata;
    logic                 ord_we;
    logic                 ord_re;
    logic [SLOT_BITS-1:0] ord_waddr;
    logic [SLOT_BITS-1:0] ord_raddr;
    logic [SLOT_BITS-1:0] ord_wdata;
  } store_req_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_SORT,
    S_HASH_LO,
    S_HASH_HI,
    S_PROBE,
    S_CHECK,
    S_RD_ORDER,
    S_RD_SLOT,
    S_RD_DATA,
    S_RESULT
  } state_t;

endpackage

// ===== rtl/core/mesh_edge_adjacency_table.sv =====
// Channel | dir | tdata (low bit up)                          | tuser
// s       | in  | vertex_a, vertex_b, vertex_c, edge_index    | opcode
// m       | out | edge_count, edge_low, edge_high, first, 2nd | status
//
// One word at a time. Add, per edge: sort, a low and a high hash step on one shared
// 13x13 multiplier, slot read, check/write; each extra probe of the single-port slot
// memory repeats the slot read and the check. Result, then idle. Read: order read,
// slot read, data capture, result; out-of-range read, no-op, add at the limit: result.
// Clear and reset run a sweep over all 8192 slots of the slot memory, s_tready low.
// A result waiting on m_tready does not block the next word from entering.
// Top level of the mesh edge adjacency table; depends on mea_pkg, mea_store.
module mesh_edge_adjacency_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // vertex_a, vertex_b, vertex_c, edge_index, pad
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // edge_count, edge_low, edge_high, first, second, pad
  output logic [1:0]  m_tuser    // status
);
  import mea_pkg::*;

  state_t state, state_next;

  logic [VERTEX_BITS-1:0] va, vb, vc;
  logic [1:0]             edge_sel;
  logic [VERTEX_BITS-1:0] key_lo, key_hi;
  logic [SLOT_BITS-1:0]   hash_part;
  logic [SLOT_BITS-1:0]   probe_idx;
  logic [SLOT_BITS-1:0]   probe_cnt;
  logic [TRI_ID_BITS-1:0] tri_id;
  logic                   full_flag;
  logic [COUNT_BITS-1:0]  stored;
  logic [TRI_BITS-1:0]    tri_seen;
  logic [SLOT_BITS-1:0]   sweep_addr;
  logic                   sweep_to_result;
  logic [SLOT_BITS-1:0]   rd_index;
  status_t                res_status;
  logic [VERTEX_BITS-1:0] res_lo, res_hi;
  logic [TRI_BITS-1:0]    res_first, res_second;

  store_req_t             req;
  slot_t                  slot_rdata;
  logic [SLOT_BITS-1:0]   ord_rdata;

  logic                   accept;
  op_t                    in_op;
  logic [SLOT_BITS-1:0]   mul_a, mul_b;
  logic [2*SLOT_BITS-1:0] mul_p;
  logic [VERTEX_BITS-1:0] pick_p, pick_q;
  logic                   key_match, last_probe, last_edge, out_free;

  assign accept   = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // shared multiplier: low key in S_HASH_LO, high key otherwise
  always_comb begin
    mul_a = (state == S_HASH_LO) ? key_lo[SLOT_BITS-1:0] : key_hi[SLOT_BITS-1:0];
    mul_b = (state == S_HASH_LO) ? HASH_LOW_TRIM : HASH_HIGH_TRIM;
    mul_p = mul_a * mul_b;
  end

  // edge selection: (a,b), (b,c), (c,a)
  always_comb begin
    case (edge_sel)
      2'd0:    begin pick_p = va; pick_q = vb; end
      2'd1:    begin pick_p = vb; pick_q = vc; end
      default: begin pick_p = vc; pick_q = va; end
    endcase
  end

  assign key_match  = (slot_rdata.lo == key_lo) && (slot_rdata.hi == key_hi);
  assign last_probe = (probe_cnt == '1);
  assign last_edge  = (edge_sel == 2'd2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_addr == '1) state_next = sweep_to_result ? S_RESULT : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_ADD:   state_next = (tri_seen >= TRI_LIMIT) ? S_RESULT : S_SORT;
            OP_READ:  state_next = ({1'b0, s_tdata[72:60]} >= stored) ? S_RESULT
                                                                      : S_RD_ORDER;
            OP_CLEAR: state_next = S_SWEEP;
            default:  state_next = S_RESULT;
          endcase
        end
      end
      S_SORT:     state_next = S_HASH_LO;
      S_HASH_LO:  state_next = S_HASH_HI;
      S_HASH_HI:  state_next = S_PROBE;
      S_PROBE:    state_next = S_CHECK;
      S_CHECK: begin
        if (slot_rdata.valid && !key_match && !last_probe) state_next = S_PROBE;
        else state_next = last_edge ? S_RESULT : S_SORT;
      end
      S_RD_ORDER: state_next = S_RD_SLOT;
      S_RD_SLOT:  state_next = S_RD_DATA;
      S_RD_DATA:  state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    req            = '0;
    req.slot_addr  = probe_idx;
    req.ord_waddr  = stored[SLOT_BITS-1:0];
    req.ord_raddr  = rd_index;
    req.ord_wdata  = probe_idx;
    unique case (state)
      S_SWEEP: begin
        req.slot_we   = 1'b1;
        req.slot_addr = sweep_addr;
      end
      S_PROBE: req.slot_re = 1'b1;
      S_CHECK: begin
        if (!slot_rdata.valid) begin
          req.slot_we    = 1'b1;
          req.slot_wdata = '{valid: 1'b1, lo: key_lo, hi: key_hi,
                             first: tri_id, second: NO_TRI};
          req.ord_we     = 1'b1;
        end else if (key_match && slot_rdata.second == NO_TRI) begin
          req.slot_we           = 1'b1;
          req.slot_wdata        = slot_rdata;
          req.slot_wdata.second = {1'b0, tri_id};
        end
      end
      S_RD_ORDER: req.ord_re = 1'b1;
      S_RD_SLOT: begin
        req.slot_re   = 1'b1;
        req.slot_addr = ord_rdata;
      end
      default: ;
    endcase
  end

  mea_store u_store (
    .clk        (clk),
    .req        (req),
    .slot_rdata (slot_rdata),
    .ord_rdata  (ord_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_SWEEP;
      sweep_addr      <= '0;
      sweep_to_result <= 1'b0;
      stored          <= '0;
      tri_seen        <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) sweep_addr <= sweep_addr + 1'b1;
      if (accept && in_op == OP_ADD && tri_seen < TRI_LIMIT) tri_seen <= tri_seen + 1'b1;
      if (accept && in_op == OP_CLEAR) begin
        stored          <= '0;
        tri_seen        <= '0;
        sweep_addr      <= '0;
        sweep_to_result <= 1'b1;
      end
      if (state == S_CHECK && !slot_rdata.valid) stored <= stored + 1'b1;
      if (state == S_RESULT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      va         <= s_tdata[19:0];
      vb         <= s_tdata[39:20];
      vc         <= s_tdata[59:40];
      rd_index   <= s_tdata[72:60];
      tri_id     <= tri_seen[TRI_ID_BITS-1:0];
      edge_sel   <= 2'd0;
      full_flag  <= 1'b0;
      res_lo     <= '0;
      res_hi     <= '0;
      res_first  <= NO_TRI;
      res_second <= NO_TRI;
      res_status <= (in_op == OP_ADD && tri_seen >= TRI_LIMIT) ? ST_TRI_LIMIT :
                    (in_op == OP_READ && {1'b0, s_tdata[72:60]} >= stored) ? ST_RANGE :
                    ST_OK;
    end
    case (state)
      S_SORT: begin
        key_lo <= (pick_p < pick_q) ? pick_p : pick_q;
        key_hi <= (pick_p < pick_q) ? pick_q : pick_p;
      end
      S_HASH_LO: hash_part <= mul_p[SLOT_BITS-1:0];
      S_HASH_HI: begin
        probe_idx <= hash_part ^ mul_p[SLOT_BITS-1:0];
        probe_cnt <= '0;
      end
      S_CHECK: begin
        if (slot_rdata.valid && !key_match && !last_probe) begin
          probe_idx <= probe_idx + 1'b1;
          probe_cnt <= probe_cnt + 1'b1;
        end else begin
          edge_sel <= edge_sel + 1'b1;
          if (slot_rdata.valid && !key_match) full_flag <= 1'b1;
          if (last_edge && (full_flag || (slot_rdata.valid && !key_match)))
            res_status <= ST_FULL;
        end
      end
      S_RD_DATA: begin
        res_lo     <= slot_rdata.lo;
        res_hi     <= slot_rdata.hi;
        res_first  <= {1'b0, slot_rdata.first};
        res_second <= slot_rdata.second;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {2'b00, res_second, res_first, res_hi, res_lo, stored};
    end
  end

endmodule

// ===== rtl/core/mea_store.sv =====
// Slot memory (hash table words) and order memory (edge number to slot).
// Depends on mea_pkg.
module mea_store (
  input  logic                           clk,
  input  mea_pkg::store_req_t            req,
  output mea_pkg::slot_t                 slot_rdata,
  output logic [mea_pkg::SLOT_BITS-1:0]  ord_rdata
);
  import mea_pkg::*;

  slot_t                slot_mem [HASH_SLOTS];
  logic [SLOT_BITS-1:0] ord_mem  [HASH_SLOTS];

  // single-port slot memory, registered read
  always_ff @(posedge clk) begin
    if (req.slot_we) begin
      slot_mem[req.slot_addr] <= req.slot_wdata;
    end
    if (req.slot_re) begin
      slot_rdata <= slot_mem[req.slot_addr];
    end
  end

  // order memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.ord_we) begin
      ord_mem[req.ord_waddr] <= req.ord_wdata;
    end
    if (req.ord_re) begin
      ord_rdata <= ord_mem[req.ord_raddr];
    end
  end

endmodule

// ===== rtl/core/mea_checker.sv =====
// Port-level checker for the mesh edge adjacency table, bound to the top.
// Depends on mea_pkg and mesh_edge_adjacency_table_assert.svh.
`include "mesh_edge_adjacency_table_assert.svh"

module mea_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import mea_pkg::*;

  // one word in flight: busy right after an accept
  `MEA_ASSERT_NXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
  // a stalled result stays
  `MEA_ASSERT_NXT(result_held, m_tvalid && !m_tready, m_tvalid)
  // out-of-range read names no edge
  `MEA_ASSERT_IMP(range_no_edge, m_tvalid && m_tuser == ST_RANGE,
    m_tdata[53:14] == '0 && m_tdata[65:54] == NO_TRI && m_tdata[77:66] == NO_TRI)
  // count never exceeds the slot count
  `MEA_ASSERT_IMP(count_bound, m_tvalid, m_tdata[13:0] <= COUNT_BITS'(HASH_SLOTS))

endmodule

bind mesh_edge_adjacency_table mea_checker u_mea_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== bench/mesh_edge_adjacency_table_tb.sv =====
// Self-checking bench for mesh_edge_adjacency_table: directed words, random mesh
// traffic and a run up to the triangle limit, checked against an in-bench model.
// Depends on mea_pkg and the RTL of the table.
module mesh_edge_adjacency_table_tb;
  import mea_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_WORDS = 1250;

  typedef struct packed {
    status_t                status;
    logic [COUNT_BITS-1:0]  count;
    logic [VERTEX_BITS-1:0] lo;
    logic [VERTEX_BITS-1:0] hi;
    logic [TRI_BITS-1:0]    first;
    logic [TRI_BITS-1:0]    second;
  } edge_reply_t;

  typedef struct {
    op_t                    op;
    logic [VERTEX_BITS-1:0] a, b, c;
    logic [SLOT_BITS-1:0]   idx;
    bit                     fixed;
    edge_reply_t            want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // vertex_a, vertex_b, vertex_c, edge_index, pad
  logic [1:0]  s_tuser = OP_NOP;   // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;   // edge_count, edge_low, edge_high, first, second, pad
  logic [1:0]  m_tuser;   // status

  mesh_edge_adjacency_table u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the edge table
  bit                     slot_used [HASH_SLOTS];
  logic [VERTEX_BITS-1:0] slot_lo [HASH_SLOTS];
  logic [VERTEX_BITS-1:0] slot_hi [HASH_SLOTS];
  logic [TRI_BITS-1:0]    slot_tri1 [HASH_SLOTS];
  logic [TRI_BITS-1:0]    slot_tri2 [HASH_SLOTS];
  int unsigned            edge_slot [HASH_SLOTS];
  int unsigned            edge_total = 0;
  int unsigned            tri_total = 0;

  edge_reply_t replies_due[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  // returns 0 when a new edge finds no free slot
  function automatic bit add_edge(logic [VERTEX_BITS-1:0] p, logic [VERTEX_BITS-1:0] q,
                                  logic [TRI_BITS-1:0] tri_id);
    logic [VERTEX_BITS-1:0] lo, hi;
    longint unsigned h;
    int unsigned s;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    h = (longint'(lo) * 73856093) ^ (longint'(hi) * 19349663);
    s = 32'(h % HASH_SLOTS);
    for (int n = 0; n < HASH_SLOTS; n++) begin
      if (!slot_used[s]) begin
        slot_used[s] = 1'b1;
        slot_lo[s] = lo;
        slot_hi[s] = hi;
        slot_tri1[s] = tri_id;
        slot_tri2[s] = NO_TRI;
        edge_slot[edge_total] = s;
        edge_total++;
        return 1'b1;
      end
      if (slot_lo[s] == lo && slot_hi[s] == hi) begin
        if (slot_tri2[s] == NO_TRI) slot_tri2[s] = tri_id;
        return 1'b1;
      end
      s = (s + 1) % HASH_SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic edge_reply_t table_step(op_t op, logic [VERTEX_BITS-1:0] a,
      logic [VERTEX_BITS-1:0] b, logic [VERTEX_BITS-1:0] c, logic [SLOT_BITS-1:0] idx);
    edge_reply_t r;
    bit ok;
    int unsigned s;
    r = '{status: ST_OK, count: '0, lo: '0, hi: '0, first: NO_TRI, second: NO_TRI};
    case (op)
      OP_ADD: begin
        if (tri_total >= MAX_TRIANGLES) begin
          r.status = ST_TRI_LIMIT;
        end else begin
          ok = add_edge(a, b, TRI_BITS'(tri_total));
          ok &= add_edge(b, c, TRI_BITS'(tri_total));
          ok &= add_edge(c, a, TRI_BITS'(tri_total));
          tri_total++;
          if (!ok) r.status = ST_FULL;
        end
      end
      OP_READ: begin
        if (idx >= edge_total) begin
          r.status = ST_RANGE;
        end else begin
          s = edge_slot[idx];
          r.lo = slot_lo[s];
          r.hi = slot_hi[s];
          r.first = slot_tri1[s];
          r.second = slot_tri2[s];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < HASH_SLOTS; i++) slot_used[i] = 1'b0;
        edge_total = 0;
        tri_total = 0;
      end
      default: ;
    endcase
    r.count = COUNT_BITS'(edge_total);
    return r;
  endfunction

  // one word into the slave side; inputs move on the falling edge
  task automatic send_word(op_t op, logic [VERTEX_BITS-1:0] a, logic [VERTEX_BITS-1:0] b,
      logic [VERTEX_BITS-1:0] c, logic [SLOT_BITS-1:0] idx, bit fixed, edge_reply_t want);
    edge_reply_t r;
    if (!calm && $urandom_range(0, 99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 32) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, idx, c, b, a};
    do @(posedge clk); while (!s_tready);
    r = table_step(op, a, b, c, idx);
    replies_due.insert(replies_due.size(), fixed ? want : r);
    @(negedge clk);
  endtask

  task automatic report(string what, logic [79:0] got, logic [79:0] exp);
    $display("mismatch %s: got %h, expected %h", what, got, exp);
    mismatches++;
  endtask

  // master side: random back-pressure
  always @(negedge clk)
    if (!rst) m_tready <= calm || ($urandom_range(0, 99) >= 32);

  // reply checker
  always @(posedge clk) begin
    edge_reply_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        report("unexpected word", m_tdata, '0);
      end else begin
        e = replies_due.pop_front();
        if (m_tuser != e.status) report("status", m_tuser, e.status);
        if (m_tdata[13:0] != e.count) report("edge_count", m_tdata[13:0], e.count);
        if (m_tdata[33:14] != e.lo) report("edge_low", m_tdata[33:14], e.lo);
        if (m_tdata[53:34] != e.hi) report("edge_high", m_tdata[53:34], e.hi);
        if (m_tdata[65:54] != e.first) report("first_triangle", m_tdata[65:54], e.first);
        if (m_tdata[77:66] != e.second) report("second_triangle", m_tdata[77:66], e.second);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mesh_edge_adjacency_table_tb: errors");
      $finish;
    end
  end

  function automatic logic [VERTEX_BITS-1:0] pick_vertex(logic [VERTEX_BITS-1:0] base);
    if ($urandom_range(0, 7) == 0) return VERTEX_BITS'($urandom);
    return base + VERTEX_BITS'($urandom_range(0, 23));
  endfunction

  initial begin
    stim_row_t rows[$];
    edge_reply_t none;
    logic [VERTEX_BITS-1:0] base;
    int unsigned pick;
    int calm_from;
    none = '{status: ST_OK, count: '0, lo: '0, hi: '0, first: NO_TRI, second: NO_TRI};

    // directed table; fixed rows carry the reply read straight off the spec
    rows = '{
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd0, 1,
        '{ST_RANGE, 14'd0, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_NOP, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 13'h1FFF, 1,
        '{ST_OK, 14'd0, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_ADD, 20'd0, 20'd1, 20'd2, 13'd0, 1,
        '{ST_OK, 14'd3, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd0, 1,
        '{ST_OK, 14'd3, 20'd0, 20'd1, 12'd0, NO_TRI}},
      '{OP_ADD, 20'hFFFFF, 20'd0, 20'd1, 13'h1FFF, 0, none},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'h1FFF, 1,
        '{ST_RANGE, 14'd5, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_READ, 20'hFFFFF, 20'd0, 20'd0, 13'd3, 0, none},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd0, 0, none},
      '{OP_ADD, 20'd7, 20'd7, 20'd7, 13'd0, 0, none},   // degenerate: one edge thrice
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd5, 0, none},
      '{OP_ADD, 20'd5, 20'd5, 20'd9, 13'd0, 0, none},
      '{OP_ADD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 13'd0, 0, none},
      '{OP_ADD, 20'd1, 20'd0, 20'd2, 13'd0, 0, none},   // third user of edge (0,1)
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd0, 0, none},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd9, 0, none},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd10, 0, none},
      '{OP_CLEAR, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 13'h1FFF, 1,
        '{ST_OK, 14'd0, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_READ, 20'd0, 20'd0, 20'd0, 13'd0, 1,
        '{ST_RANGE, 14'd0, 20'd0, 20'd0, NO_TRI, NO_TRI}},
      '{OP_ADD, 20'h55555, 20'hAAAAA, 20'h12345, 13'h0AAA, 0, none},
      '{OP_READ, 20'hAAAAA, 20'h55555, 20'd0, 13'd2, 0, none},
      '{OP_NOP, 20'd0, 20'd0, 20'd0, 13'd0, 0, none}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_word(rows[i].op, rows[i].a, rows[i].b, rows[i].c, rows[i].idx,
                rows[i].fixed, rows[i].want);

    // random mesh traffic on a small vertex neighborhood so edges get shared
    base = VERTEX_BITS'($urandom);
    calm_from = $urandom_range(300, 700);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= calm_from && n < calm_from + 200);
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_word(OP_ADD, pick_vertex(base), pick_vertex(base), pick_vertex(base),
                  SLOT_BITS'($urandom), 0, none);
      else if (pick < 85 && edge_total > 0)
        send_word(OP_READ, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom), '0,
                  SLOT_BITS'($urandom_range(0, edge_total - 1)), 0, none);
      else if (pick < 92)
        send_word(OP_READ, '0, '0, VERTEX_BITS'($urandom), SLOT_BITS'($urandom), 0, none);
      else if (pick < 94) begin
        send_word(OP_CLEAR, VERTEX_BITS'($urandom), '0, '0, SLOT_BITS'($urandom), 0, none);
        base = VERTEX_BITS'($urandom);
      end else
        send_word(OP_NOP, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom),
                  VERTEX_BITS'($urandom), SLOT_BITS'($urandom), 0, none);
    end
    calm = 1'b0;

    // fill up to the triangle limit and beyond, then read back
    send_word(OP_CLEAR, '0, '0, '0, '0, 0, none);
    for (int n = 0; n < MAX_TRIANGLES + 6; n++)
      send_word(OP_ADD, pick_vertex(base), pick_vertex(base), pick_vertex(base),
                '0, 0, none);
    for (int n = 0; n < 20; n++)
      send_word(OP_READ, '0, '0, '0, SLOT_BITS'($urandom_range(0, 8191)), 0, none);
    send_word(OP_READ, '0, '0, '0, SLOT_BITS'(edge_total - 1), 0, none);
    send_word(OP_CLEAR, '0, '0, '0, '0, 0, none);
    send_word(OP_ADD, 20'd3, 20'd4, 20'd5, '0, 0, none);
    s_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("mesh_edge_adjacency_table_tb: clean");
    end else begin
      $display("mesh_edge_adjacency_table_tb: errors");
    end
    $finish;
  end

endmodule
